// File: rtl/core/psch_pkg.sv
// ----------------------------------------------------------------------------
// psch_pkg
// Types shared by the priority schedule core: input beat, result beat,
// stored process entry and accumulator control.
// ----------------------------------------------------------------------------
package psch_pkg;

  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 7;
  localparam int TICK_W  = 22;
  localparam int TOTAL_W = 28;

  typedef struct packed {
    logic [BURST_W-1:0] burst_len;
    logic [PRIO_W-1:0]  priority_req;
    logic               last_process;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]    process_number;
    logic [PRIO_W-1:0]  process_priority;
    logic [BURST_W-1:0] process_burst;
    logic [TICK_W-1:0]  wait_ticks;
    logic [TICK_W-1:0]  turnaround_ticks;
    logic [TOTAL_W-1:0] wait_total;
    logic [TOTAL_W-1:0] turnaround_total;
    logic               final_result;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } acc_ctl_t;

endpackage

// File: rtl/core/psch_store.sv
// ----------------------------------------------------------------------------
// psch_store
// Process entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psch_store #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  psch_pkg::entry_t wdata,
  input  logic [IDX_W-1:0] raddr,
  output psch_pkg::entry_t rdata
);
  import psch_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/psch_acc.sv
// ----------------------------------------------------------------------------
// psch_acc
// Schedule accumulator: running wait time and totals, registered result beat.
// ----------------------------------------------------------------------------
module psch_acc (
  input  logic               clk,
  input  logic               rst,
  input  psch_pkg::acc_ctl_t ctl,
  input  psch_pkg::entry_t   ent,
  output logic               done,
  output psch_pkg::out_t     result
);
  import psch_pkg::*;

  logic [TICK_W-1:0]  wait_acc;
  logic [TOTAL_W-1:0] wsum;
  logic [TOTAL_W-1:0] tsum;
  logic [TICK_W-1:0]  turn;
  logic [TOTAL_W-1:0] wsum_next;
  logic [TOTAL_W-1:0] tsum_next;

  assign turn      = wait_acc + TICK_W'(ent.burst);
  assign wsum_next = wsum + TOTAL_W'(wait_acc);
  assign tsum_next = tsum + TOTAL_W'(turn);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      wait_acc <= '0;
      wsum     <= '0;
      tsum     <= '0;
    end else if (ctl.valid) begin
      wait_acc <= turn;
      wsum     <= wsum_next;
      tsum     <= tsum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      result.process_number   <= ent.id;
      result.process_priority <= ent.prio;
      result.process_burst    <= ent.burst;
      result.wait_ticks       <= wait_acc;
      result.turnaround_ticks <= turn;
      result.wait_total       <= wsum_next;
      result.turnaround_total <= tsum_next;
      result.final_result     <= ctl.last;
    end
  end

endmodule

// File: rtl/core/priority_schedule_times_core.sv
// ----------------------------------------------------------------------------
// priority_schedule_times_core
// Non-preemptive priority scheduler: loads processes, selection-sorts them in
// place in the entry memory by ascending priority, then streams the schedule.
//
//   channel | handshake        | payload   | beat
//   --------+------------------+-----------+--------------------------------
//   input   | start, busy      | in_item   | start & !busy
//   result  | done             | result    | done (one cycle, no backpressure)
//
// Loading takes one process per cycle while idle. On the last process the
// sort runs: each position reads every entry from it to the end, one
// memory read per entry scanned, then swaps through the single write port
// in ST_SWAP_A and ST_SWAP_B. Emit then does one memory read per result.
// busy is high from the last process until the final result beat.
// Synchronous reset clears the count and control; memory contents are kept.
// ----------------------------------------------------------------------------
module priority_schedule_times_core #(
  parameter int MAX_PROCESSES = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  psch_pkg::in_t   in_item,
  output logic            done,
  output psch_pkg::out_t  result
);
  import psch_pkg::*;

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_SWAP_A = 3'd2;
  localparam logic [2:0] ST_SWAP_B = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;       // sort position
  logic [CNT_W-1:0] iss;       // next read address
  logic             rv;        // read data valid this cycle
  logic [IDX_W-1:0] ridx;      // index of read data
  logic [IDX_W-1:0] best_idx;
  entry_t           cur;
  entry_t           best;

  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;
  entry_t           rdata;
  logic             accept;
  logic             room;
  logic [CNT_W-1:0] n_after;
  logic             issue;
  logic             ret_last;
  acc_ctl_t         acc_ctl;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign room     = (count < CNT_W'(MAX_PROCESSES));
  assign n_after  = room ? count + CNT_W'(1) : count;
  assign issue    = (iss < count);
  assign ret_last = rv && (CNT_W'(ridx) == count - CNT_W'(1));

  always_comb begin
    we    = 1'b0;
    waddr = count[IDX_W-1:0];
    wdata = cur;
    unique case (state)
      ST_IDLE: begin
        we          = accept && room;
        waddr       = count[IDX_W-1:0];
        wdata.id    = ID_W'(count) + ID_W'(1);
        wdata.prio  = in_item.priority_req;
        wdata.burst = in_item.burst_len;
      end
      ST_SWAP_A: begin
        we    = 1'b1;
        waddr = best_idx;
        wdata = cur;
      end
      ST_SWAP_B: begin
        we    = 1'b1;
        waddr = pos[IDX_W-1:0];
        wdata = best;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    acc_ctl.clear = accept && in_item.last_process && (n_after == CNT_W'(1));
    acc_ctl.clear = acc_ctl.clear ||
                    (state == ST_SWAP_B && pos + CNT_W'(2) >= count);
    acc_ctl.valid = (state == ST_EMIT) && rv;
    acc_ctl.last  = ret_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rv    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          rv <= 1'b0;
          if (accept) begin
            count <= n_after;
            if (in_item.last_process) begin
              pos <= '0;
              iss <= '0;
              state <= (n_after == CNT_W'(1)) ? ST_EMIT : ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rv   <= issue;
          ridx <= iss[IDX_W-1:0];
          if (issue) begin
            iss <= iss + CNT_W'(1);
          end
          if (rv) begin
            if (CNT_W'(ridx) == pos) begin
              cur      <= rdata;
              best     <= rdata;
              best_idx <= ridx;
            end else if (rdata.prio < best.prio) begin
              best     <= rdata;
              best_idx <= ridx;
            end
          end
          if (ret_last) begin
            state <= ST_SWAP_A;
          end
        end
        ST_SWAP_A: begin
          rv    <= 1'b0;
          state <= ST_SWAP_B;
        end
        ST_SWAP_B: begin
          rv <= 1'b0;
          if (pos + CNT_W'(2) < count) begin
            pos   <= pos + CNT_W'(1);
            iss   <= pos + CNT_W'(1);
            state <= ST_SCAN;
          end else begin
            iss   <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // all reads are issued by the last return, so rv drops here too
          rv   <= issue;
          ridx <= iss[IDX_W-1:0];
          if (issue) begin
            iss <= iss + CNT_W'(1);
          end
          if (ret_last) begin
            count <= '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  psch_store #(
    .DEPTH (MAX_PROCESSES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (iss[IDX_W-1:0]),
    .rdata (rdata)
  );

  psch_acc u_acc (
    .clk    (clk),
    .rst    (rst),
    .ctl    (acc_ctl),
    .ent    (rdata),
    .done   (done),
    .result (result)
  );

  // A result beat always follows a cycle of schedule work.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without schedule work");

  // The final result beat coincides with the return to idle.
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (done && result.final_result) |-> !busy)
    else $error("final result while still busy");

  // Stored count never exceeds the memory depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PROCESSES))
    else $error("entry count overflow");

  // Read address never runs past the loaded set while scanning or emitting.
  a_iss_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_EMIT) |-> iss <= count)
    else $error("read address past loaded entries");

endmodule

// File: dv/priority_schedule_times_checker.sv
// ----------------------------------------------------------------------------
// priority_schedule_times_checker
// Watches the input and result channels of the priority schedule core. It
// keeps its own copy of the loaded process set, orders it by priority on the
// last beat, queues the expected schedule and compares every result beat
// field by field against it.
// ----------------------------------------------------------------------------
module priority_schedule_times_checker #(
  parameter int MAX_PROCESSES = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  psch_pkg::in_t  in_item,
  input  logic           done,
  input  psch_pkg::out_t result,
  output int             mismatch_count,
  output int             awaited
);
  import psch_pkg::*;

  entry_t loaded_set [MAX_PROCESSES];
  int     loaded_n = 0;
  out_t   schedule_q [$];
  int     errs = 0;
  int     outstanding = 0;

  assign mismatch_count = errs;
  assign awaited        = outstanding;

  // Selection sort with swaps, same tie behavior as the block: a later entry
  // only wins on a strictly lower priority.
  task automatic queue_schedule();
    entry_t      order [MAX_PROCESSES];
    entry_t      swap_tmp;
    int          best;
    int          i;
    int          j;
    int          k;
    logic [31:0] wait_acc;
    logic [31:0] turn_acc;
    logic [31:0] wait_sum;
    logic [31:0] turn_sum;
    out_t        slot;
    order = loaded_set;
    for (i = 0; i + 1 < loaded_n; i++) begin
      best = i;
      for (j = i + 1; j < loaded_n; j++) begin
        if (order[j].prio < order[best].prio) best = j;
      end
      swap_tmp    = order[i];
      order[i]    = order[best];
      order[best] = swap_tmp;
    end
    wait_acc = '0;
    wait_sum = '0;
    turn_sum = '0;
    for (k = 0; k < loaded_n; k++) begin
      turn_acc = wait_acc + {16'd0, order[k].burst};
      wait_sum = wait_sum + wait_acc;
      turn_sum = turn_sum + turn_acc;
      slot.process_number   = order[k].id;
      slot.process_priority = order[k].prio;
      slot.process_burst    = order[k].burst;
      slot.wait_ticks       = wait_acc[TICK_W-1:0];
      slot.turnaround_ticks = turn_acc[TICK_W-1:0];
      slot.wait_total       = wait_sum[TOTAL_W-1:0];
      slot.turnaround_total = turn_sum[TOTAL_W-1:0];
      slot.final_result     = (k == loaded_n - 1);
      schedule_q.push_back(slot);
      wait_acc = turn_acc;
    end
    loaded_n = 0;
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    logic bad;
    if (schedule_q.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("%0t: result beat with nothing expected, id %0d",
                 $realtime, got.process_number);
      return;
    end
    want = schedule_q.pop_front();
    bad = (got.process_number   != want.process_number)   ||
          (got.process_priority != want.process_priority) ||
          (got.process_burst    != want.process_burst)    ||
          (got.wait_ticks       != want.wait_ticks)       ||
          (got.turnaround_ticks != want.turnaround_ticks) ||
          (got.wait_total       != want.wait_total)       ||
          (got.turnaround_total != want.turnaround_total) ||
          (got.final_result     != want.final_result);
    if (bad) begin
      errs++;
      if (errs <= 10) begin
        $display("%0t: result mismatch (id prio burst wait turn wtot ttot fin)",
                 $realtime);
        $display("  exp %0d %0d %0d %0d %0d %0d %0d %0d", want.process_number,
                 want.process_priority, want.process_burst, want.wait_ticks,
                 want.turnaround_ticks, want.wait_total, want.turnaround_total,
                 want.final_result);
        $display("  got %0d %0d %0d %0d %0d %0d %0d %0d", got.process_number,
                 got.process_priority, got.process_burst, got.wait_ticks,
                 got.turnaround_ticks, got.wait_total, got.turnaround_total,
                 got.final_result);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      loaded_n = 0;
      schedule_q.delete();
    end else begin
      // result first: a new beat may land on the edge of the final result
      if (done) check_result(result);
      if (start && !busy) begin
        if (loaded_n < MAX_PROCESSES) begin
          loaded_set[loaded_n].id    = ID_W'(loaded_n + 1);
          loaded_set[loaded_n].prio  = in_item.priority_req;
          loaded_set[loaded_n].burst = in_item.burst_len;
          loaded_n++;
        end
        // a dropped beat on a full store still kicks off the schedule
        if (in_item.last_process) queue_schedule();
      end
    end
    outstanding = schedule_q.size();
  end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the priority schedule core: a few directed process sets
// (single process, extreme bursts and priorities, unstable ties, store
// overflow), then random sets with random gaps. Checking is done by the
// schedule checker beside the core; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import psch_pkg::*;

  localparam int MAX_PROCESSES = 32;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 150;

  localparam int BURST_RANDOM  = 0;
  localparam int BURST_EXTREME = 1;
  localparam int BURST_MAX     = 2;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  in_item;
  logic done;
  out_t result;
  int   fail_count;
  int   awaited;
  int   sent = 0;
  logic quiet = 1'b0;

  priority_schedule_times_core #(.MAX_PROCESSES(MAX_PROCESSES)) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .done    (done),
    .result  (result)
  );

  priority_schedule_times_checker #(.MAX_PROCESSES(MAX_PROCESSES)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .done           (done),
    .result         (result),
    .mismatch_count (fail_count),
    .awaited        (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // one process beat; start stays high from the drive until the accepting edge
  task automatic push_process(input logic [BURST_W-1:0] burst,
                              input logic [PRIO_W-1:0] prio, input logic last);
    in_t beat;
    int  gap;
    beat.burst_len    = burst;
    beat.priority_req = prio;
    beat.last_process = last;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // drop start before idling so the last beat is not taken twice
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (awaited == 0);
  endtask

  task automatic run_set(input int n, input int prio_hi, input int burst_mode);
    int                 i;
    logic [BURST_W-1:0] burst;
    for (i = 0; i < n; i++) begin
      case (burst_mode)
        BURST_EXTREME: begin
          burst = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        BURST_MAX: begin
          burst = '1;
        end
        default: begin
          burst = BURST_W'($urandom_range(0, 65535));
        end
      endcase
      push_process(burst, PRIO_W'($urandom_range(0, prio_hi)), i == n - 1);
    end
  endtask

  initial begin
    int target;
    int n;
    int r;
    rst     = 1'b1;
    start   = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lone process with every field at its top value
    push_process(16'hFFFF, 8'hFF, 1'b1);
    // extremes of burst and priority, equal priorities at the low end
    push_process(16'h0000, 8'hFF, 1'b0);
    push_process(16'hFFFF, 8'h00, 1'b0);
    push_process(16'h0001, 8'h00, 1'b0);
    push_process(16'hFFFF, 8'h80, 1'b1);
    // swap of the minimum reorders two equal priorities
    push_process(16'd10, 8'd5, 1'b0);
    push_process(16'd20, 8'd5, 1'b0);
    push_process(16'd30, 8'd1, 1'b1);
    // strictly descending priorities
    push_process(16'd500,   8'd200, 1'b0);
    push_process(16'd1,     8'd150, 1'b0);
    push_process(16'd40000, 8'd100, 1'b0);
    push_process(16'd7,     8'd50,  1'b0);
    push_process(16'd1234,  8'd0,   1'b1);

    // idle until the schedule has drained, then hold off a little
    drain();
    repeat ($urandom_range(3, 12)) @(negedge clk);

    // overflowing set of maximum bursts: drops beats, last one still fires
    quiet = 1'b1;
    run_set(36, 255, BURST_MAX);
    quiet = 1'b0;

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      r = $urandom_range(0, 9);
      n = (r == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        drain();
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
      r = $urandom_range(0, 9);
      run_set(n, ($urandom_range(0, 1) != 0) ? 255 : 3,
              (r == 0) ? BURST_MAX : (r == 1) ? BURST_EXTREME : BURST_RANDOM);
    end
    quiet = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
